### design/assert_macros.svh
// assertion macros shared by the distance block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GCD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gcd property failed");
`define GCD_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("gcd forbidden condition seen");
`else
`define GCD_ASSERT(lbl, prop)
`define GCD_NEVER(lbl, expr)
`endif
`endif

### design/gcd_pkg.sv
// types, constants and helper functions of the great-circle distance block
`default_nettype none
package gcd_pkg;

  localparam int CW       = 36;   // cordic datapath width
  localparam int NumIter  = 30;   // cordic steps
  localparam int SqrtBits = 31;   // root bits

  localparam logic signed [CW-1:0] CordicGain = 36'sd652032874;
  localparam logic signed [32:0]   UnitToHalfRad = 33'sd2012227627;
  localparam logic [22:0]          RadiusReset = 23'd6371000;
  localparam logic [24:0]          DistMax = 25'd26353589;
  localparam logic [30:0]          QOne = 31'd1073741824;

  localparam logic [29:0] AtanTable [10] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cord_t;

  typedef struct packed {
    logic [61:0] n;
    logic [33:0] rem;
    logic [30:0] root;
  } sq_t;

  function automatic logic signed [CW-1:0] atan_entry(input int unsigned i);
    logic signed [CW-1:0] r;
    if (i < 10) begin
      r = CW'(AtanTable[i[3:0]]);
    end else begin
      r = CW'(1) << (30 - i);
    end
    return r;
  endfunction

  // q30 product with round half up
  function automatic logic signed [31:0] qmul(input logic signed [31:0] p,
                                              input logic signed [31:0] q);
    logic signed [63:0] m;
    m = p * q + 64'sd536870912;
    return m[61:30];
  endfunction

endpackage
`default_nettype wire

### design/great_circle_distance.sv
// top level: haversine great-circle distance, fully pipelined cordic datapath
// done_o pulses when distance_m_o holds the result of an accepted beat
// throughput: one point pair per cycle, busy is always low
// depth is set by 30 rotation cells, 31 root cells and 30 vectoring cells plus ten staging regs
// reset clears the valid pipe and loads the radius with 6371000, results never stall
`default_nettype none
`include "assert_macros.svh"
module great_circle_distance (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] lat_a_i,
  input  logic signed [31:0] lon_a_i,
  input  logic signed [30:0] lat_b_i,
  input  logic signed [31:0] lon_b_i,
  input  logic               cfg_we_i,
  input  logic [22:0]        cfg_wdata_i,
  output logic               done_o,
  output logic [24:0]        distance_m_o
);

  localparam int Lat = 101;
  localparam int NegLen = 34;
  // valid bit that lines up with a_q
  localparam int HavStage = 37;

  logic [22:0] radius_q;
  logic [Lat-1:0] vld_q;
  logic accept;

  // beats are never refused
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= gcd_pkg::RadiusReset;
      vld_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
      vld_q <= {vld_q[Lat-2:0], accept};
    end
  end

  // stage 1: differences and latitude fold
  logic signed [31:0] la, lb, lfa, lfb;
  logic               nega, negb;
  logic signed [32:0] dlat_d, dlat_q;
  logic signed [33:0] dlon_d, dlon_q;
  logic signed [31:0] anga_q, angb_q;

  always_comb begin
    la = {lat_a_i[30], lat_a_i};
    lb = {lat_b_i[30], lat_b_i};
    nega = 1'b1;
    negb = 1'b1;
    // cos(l) = -cos(180 - l) beyond the poles
    if (la > 32'sd900000000) begin
      lfa = 32'sd1800000000 - la;
    end else if (la < -32'sd900000000) begin
      lfa = -32'sd1800000000 - la;
    end else begin
      lfa  = la;
      nega = 1'b0;
    end
    if (lb > 32'sd900000000) begin
      lfb = 32'sd1800000000 - lb;
    end else if (lb < -32'sd900000000) begin
      lfb = -32'sd1800000000 - lb;
    end else begin
      lfb  = lb;
      negb = 1'b0;
    end
    dlat_d = {lat_b_i[30], lat_b_i[30], lat_b_i} - {lat_a_i[30], lat_a_i[30], lat_a_i};
    dlon_d = {{2{lon_b_i[31]}}, lon_b_i} - {{2{lon_a_i[31]}}, lon_a_i};
  end

  logic [1:0] neg_q [NegLen];

  always_ff @(posedge clk_i) begin
    dlat_q   <= dlat_d;
    dlon_q   <= dlon_d;
    anga_q   <= {lfa[30:0], 1'b0};
    angb_q   <= {lfb[30:0], 1'b0};
    neg_q[0] <= {negb, nega};
    for (int j = 1; j < NegLen; j++) begin
      neg_q[j] <= neg_q[j-1];
    end
  end

  // stage 2: wrap differences into half a turn either way
  logic signed [33:0] dl_ext, wlat, wlon;
  logic signed [31:0] d2_q [4];

  always_comb begin
    dl_ext = {dlat_q[32], dlat_q};
    if (dl_ext >= 34'sd1800000000) begin
      wlat = dl_ext - 34'sd3600000000;
    end else if (dl_ext < -34'sd1800000000) begin
      wlat = dl_ext + 34'sd3600000000;
    end else begin
      wlat = dl_ext;
    end
    if (dlon_q >= 34'sd1800000000) begin
      wlon = dlon_q - 34'sd3600000000;
    end else if (dlon_q < -34'sd1800000000) begin
      wlon = dlon_q + 34'sd3600000000;
    end else begin
      wlon = dlon_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d2_q[0] <= wlat[31:0];
    d2_q[1] <= wlon[31:0];
    d2_q[2] <= anga_q;
    d2_q[3] <= angb_q;
  end

  // stages 3 and 4: degree units to half-angle radians
  logic signed [63:0] prod_q [4];
  logic signed [63:0] rnd [4];
  gcd_pkg::cord_t     rot0_q [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      rnd[c] = prod_q[c] + 64'sd1073741824;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      prod_q[c]   <= d2_q[c] * gcd_pkg::UnitToHalfRad;
      rot0_q[c].x <= gcd_pkg::CordicGain;
      rot0_q[c].y <= '0;
      rot0_q[c].z <= gcd_pkg::CW'(rnd[c] >>> 31);
    end
  end

  // four rotation chains: sin of half dlat, sin of half dlon, cos lat a, cos lat b
  gcd_pkg::cord_t rot_s [4][gcd_pkg::NumIter];

  for (genvar c = 0; c < 4; c++) begin : g_rot
    for (genvar i = 0; i < gcd_pkg::NumIter; i++) begin : g_cell
      gcd_pkg::cord_t cin;
      if (i == 0) begin : g_first
        assign cin = rot0_q[c];
      end else begin : g_next
        assign cin = rot_s[c][i-1];
      end
      gcd_rot_cell #(.Step(i)) u_cell (
        .clk_i (clk_i),
        .c_i   (cin),
        .c_o   (rot_s[c][i])
      );
    end
  end

  // haversine term, multiplies split over the m1, m2 and m3 stages
  logic signed [31:0] s_lat, s_lon, cx_a, cx_b;
  logic [1:0]         neg_end;
  logic signed [31:0] m1_p_q, m1_q_q, m1_ca_q, m1_cb_q;
  logic signed [31:0] m2_p_q, m2_q_q, m2_cb_q;
  logic signed [31:0] m3_p_q, m3_q_q;
  logic signed [32:0] hsum;
  logic [30:0]        a_d, a_q;

  always_comb begin
    s_lat   = rot_s[0][gcd_pkg::NumIter-1].y[31:0];
    s_lon   = rot_s[1][gcd_pkg::NumIter-1].y[31:0];
    cx_a    = rot_s[2][gcd_pkg::NumIter-1].x[31:0];
    cx_b    = rot_s[3][gcd_pkg::NumIter-1].x[31:0];
    neg_end = neg_q[NegLen-1];
    hsum    = {m3_p_q[31], m3_p_q} + {m3_q_q[31], m3_q_q};
    // clamp to [0,1]
    if (hsum[32]) begin
      a_d = '0;
    end else if (hsum > 33'sd1073741824) begin
      a_d = gcd_pkg::QOne;
    end else begin
      a_d = hsum[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    m1_p_q  <= gcd_pkg::qmul(s_lon, s_lon);
    m1_q_q  <= gcd_pkg::qmul(s_lat, s_lat);
    m1_ca_q <= neg_end[0] ? -cx_a : cx_a;
    m1_cb_q <= neg_end[1] ? -cx_b : cx_b;
    m2_p_q  <= gcd_pkg::qmul(m1_p_q, m1_ca_q);
    m2_q_q  <= m1_q_q;
    m2_cb_q <= m1_cb_q;
    m3_p_q  <= gcd_pkg::qmul(m2_p_q, m2_cb_q);
    m3_q_q  <= m2_q_q;
    a_q     <= a_d;
  end

  // two root chains: sqrt(a) and sqrt(1-a)
  gcd_pkg::sq_t sq0 [2];
  gcd_pkg::sq_t sq_s [2][gcd_pkg::SqrtBits];

  always_comb begin
    sq0[0].n    = {1'b0, a_q, 30'd0};
    sq0[0].rem  = '0;
    sq0[0].root = '0;
    sq0[1].n    = {1'b0, gcd_pkg::QOne - a_q, 30'd0};
    sq0[1].rem  = '0;
    sq0[1].root = '0;
  end

  for (genvar r = 0; r < 2; r++) begin : g_sq
    for (genvar i = 0; i < gcd_pkg::SqrtBits; i++) begin : g_cell
      gcd_pkg::sq_t sin;
      if (i == 0) begin : g_first
        assign sin = sq0[r];
      end else begin : g_next
        assign sin = sq_s[r][i-1];
      end
      gcd_sqrt_cell #(.Bit(gcd_pkg::SqrtBits - 1 - i)) u_cell (
        .clk_i (clk_i),
        .s_i   (sin),
        .s_o   (sq_s[r][i])
      );
    end
  end

  // central angle: atan2(sqrt(a), sqrt(1-a))
  gcd_pkg::cord_t vec0;
  gcd_pkg::cord_t vec_s [gcd_pkg::NumIter];

  always_comb begin
    vec0.x = gcd_pkg::CW'(sq_s[1][gcd_pkg::SqrtBits-1].root);
    vec0.y = gcd_pkg::CW'(sq_s[0][gcd_pkg::SqrtBits-1].root);
    vec0.z = '0;
  end

  for (genvar i = 0; i < gcd_pkg::NumIter; i++) begin : g_vec
    gcd_pkg::cord_t cin;
    if (i == 0) begin : g_first
      assign cin = vec0;
    end else begin : g_next
      assign cin = vec_s[i-1];
    end
    gcd_vec_cell #(.Step(i)) u_cell (
      .clk_i (clk_i),
      .c_i   (cin),
      .c_o   (vec_s[i])
    );
  end

  // scale by radius, round, saturate
  logic signed [33:0] two_z;
  logic signed [23:0] rad_s;
  logic signed [57:0] dist_prod_q;
  logic signed [27:0] dist_sh;
  logic [24:0]        dist_d, dist_q;

  always_comb begin
    two_z   = {vec_s[gcd_pkg::NumIter-1].z[32:0], 1'b0};
    rad_s   = {1'b0, radius_q};
    dist_sh = dist_prod_q[57:30];
    if (dist_sh[27]) begin
      dist_d = '0;
    end else if (dist_sh > $signed({3'b000, gcd_pkg::DistMax})) begin
      dist_d = gcd_pkg::DistMax;
    end else begin
      dist_d = dist_sh[24:0];
    end
  end

  always_ff @(posedge clk_i) begin
    dist_prod_q <= rad_s * two_z + 58'sd536870912;
    dist_q      <= dist_d;
  end

  assign done_o       = vld_q[Lat-1];
  assign distance_m_o = dist_q;

  `GCD_ASSERT(a_lat_hit, start |-> ##Lat done_o)
  `GCD_ASSERT(a_lat_none, !start |-> ##Lat !done_o)
  `GCD_NEVER(a_hav_range, vld_q[HavStage] && (a_q > gcd_pkg::QOne))
  `GCD_NEVER(a_dist_range, done_o && (distance_m_o > gcd_pkg::DistMax))

endmodule
`default_nettype wire

### design/gcd_rot_cell.sv
// one rotation step of the sine/cosine cordic chain
`default_nettype none
module gcd_rot_cell #(
  parameter int unsigned Step = 0
) (
  input  logic           clk_i,
  input  gcd_pkg::cord_t c_i,
  output gcd_pkg::cord_t c_o
);

  logic signed [gcd_pkg::CW-1:0] x, y, z, xs, ys, at;
  gcd_pkg::cord_t c_d, c_q;

  always_comb begin
    x  = c_i.x;
    y  = c_i.y;
    z  = c_i.z;
    xs = x >>> Step;
    ys = y >>> Step;
    at = gcd_pkg::atan_entry(Step);
    if (!z[gcd_pkg::CW-1]) begin
      c_d.x = x - ys;
      c_d.y = y + xs;
      c_d.z = z - at;
    end else begin
      c_d.x = x + ys;
      c_d.y = y - xs;
      c_d.z = z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
  end

  assign c_o = c_q;

endmodule
`default_nettype wire

### design/gcd_vec_cell.sv
// one vectoring step of the arctangent cordic chain
`default_nettype none
module gcd_vec_cell #(
  parameter int unsigned Step = 0
) (
  input  logic           clk_i,
  input  gcd_pkg::cord_t c_i,
  output gcd_pkg::cord_t c_o
);

  logic signed [gcd_pkg::CW-1:0] x, y, z, xs, ys, at;
  gcd_pkg::cord_t c_d, c_q;

  always_comb begin
    x  = c_i.x;
    y  = c_i.y;
    z  = c_i.z;
    xs = x >>> Step;
    ys = y >>> Step;
    at = gcd_pkg::atan_entry(Step);
    if (!y[gcd_pkg::CW-1]) begin
      c_d.x = x + ys;
      c_d.y = y - xs;
      c_d.z = z + at;
    end else begin
      c_d.x = x - ys;
      c_d.y = y + xs;
      c_d.z = z - at;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
  end

  assign c_o = c_q;

endmodule
`default_nettype wire

### design/gcd_sqrt_cell.sv
// one root bit of the pipelined restoring square root
`default_nettype none
module gcd_sqrt_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic         clk_i,
  input  gcd_pkg::sq_t s_i,
  output gcd_pkg::sq_t s_o
);

  logic [33:0] rem_sh, trial;
  gcd_pkg::sq_t s_d, s_q;

  always_comb begin
    rem_sh = {s_i.rem[31:0], s_i.n[2*Bit+1 -: 2]};
    trial  = {1'b0, s_i.root, 2'b01};
    s_d.n  = s_i.n;
    if (rem_sh >= trial) begin
      s_d.rem  = rem_sh - trial;
      s_d.root = {s_i.root[29:0], 1'b1};
    end else begin
      s_d.rem  = rem_sh;
      s_d.root = {s_i.root[29:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
  end

  assign s_o = s_q;

endmodule
`default_nettype wire
